// ===== rtl/button_debounce_event_queue_assert.svh =====
// Assertion helpers for the debounce event queue.
`ifndef BUTTON_DEBOUNCE_EVENT_QUEUE_ASSERT_SVH
`define BUTTON_DEBOUNCE_EVENT_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

`define BDEQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`define BDEQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define BDEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define BDEQ_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg)

`define BDEQ_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)

`define BDEQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/bdeq_pkg.sv =====
package bdeq_pkg;

  typedef enum logic [1:0] {
    ACT_PRESS = 2'd0,
    ACT_POP   = 2'd1,
    ACT_FLUSH = 2'd2
  } action_t;

  localparam int          TIME_W       = 32;
  localparam int          WINDOW_W     = 16;
  localparam int          PENDING_W    = 3;
  localparam int          EVENT_W      = TIME_W + 1;
  localparam logic [15:0] WINDOW_RESET = 16'd20;

  typedef struct packed {
    action_t            action;
    logic               button;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic                  press_accepted;
    logic                  event_dropped;
    logic                  pop_valid;
    logic                  event_button;
    logic [TIME_W-1:0]     event_time;
    logic [PENDING_W-1:0]  pending_count;
    logic [TIME_W-1:0]     first_press_total;
    logic [TIME_W-1:0]     second_press_total;
  } res_t;

endpackage

// ===== rtl/bdeq_in_if.sv =====
interface bdeq_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic        button;
  logic [31:0] now_ms;

  modport source (output valid, action, button, now_ms, input ready);
  modport sink   (input valid, action, button, now_ms, output ready);
endinterface

// ===== rtl/bdeq_out_if.sv =====
interface bdeq_out_if;
  logic        valid;
  logic        ready;
  logic        press_accepted;
  logic        event_dropped;
  logic        pop_valid;
  logic        event_button;
  logic [31:0] event_time;
  logic [2:0]  pending_count;
  logic [31:0] first_press_total;
  logic [31:0] second_press_total;

  modport source (output valid, press_accepted, event_dropped, pop_valid, event_button,
                  event_time, pending_count, first_press_total, second_press_total,
                  input ready);
  modport sink   (input valid, press_accepted, event_dropped, pop_valid, event_button,
                  event_time, pending_count, first_press_total, second_press_total,
                  output ready);
endinterface

// ===== rtl/bdeq_ram.sv =====
module bdeq_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/bdeq_core.sv =====
`include "button_debounce_event_queue_assert.svh"

module bdeq_core #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [15:0]                         cfg_wdata,
  input  logic                                item_valid,
  input  bdeq_pkg::in_item_t                  item,
  output bdeq_pkg::res_t                      res,
  output logic                                ram_we,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_waddr,
  output logic [bdeq_pkg::EVENT_W-1:0]        ram_wdata,
  output logic [$clog2(QUEUE_DEPTH)-1:0]      ram_raddr,
  input  logic [bdeq_pkg::EVENT_W-1:0]        ram_rdata
);
  import bdeq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [PW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]       count_r, count_nxt;
  logic [TIME_W-1:0]   last_r [2];
  logic [TIME_W-1:0]   last_nxt [2];
  logic [TIME_W-1:0]   total_r [2];
  logic [TIME_W-1:0]   total_nxt [2];
  logic [WINDOW_W-1:0] window_r;
  logic                byp_hit_r, byp_hit_nxt;
  logic [EVENT_W-1:0]  byp_data_r;

  logic [TIME_W-1:0]   elapsed;
  logic                debounce_ok;
  logic                full;
  logic                empty;
  logic [EVENT_W-1:0]  rd_data;
  logic [PW+2:0]       cnt_wide;

  function automatic logic [PW-1:0] advance(input logic [PW-1:0] p);
    logic [PW-1:0] q;
    if (p == PW'(QUEUE_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + 1'b1;
    end
    return q;
  endfunction

  assign elapsed     = item.now_ms - last_r[item.button];
  assign debounce_ok = elapsed >= {16'b0, window_r};
  assign full        = count_r == PW'(QUEUE_DEPTH - 1);
  assign empty       = count_r == '0;
  // write landing on the slot being read in the same cycle: RAM returns old data
  assign rd_data     = byp_hit_r ? byp_data_r : ram_rdata;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    last_nxt   = last_r;
    total_nxt  = total_r;
    ram_we     = 1'b0;
    res        = '0;

    if (item_valid) begin
      case (item.action)
        ACT_PRESS: begin
          if (debounce_ok) begin
            res.press_accepted       = 1'b1;
            last_nxt[item.button]    = item.now_ms;
            total_nxt[item.button]   = total_r[item.button] + 1'b1;
            if (full) begin
              res.event_dropped = 1'b1;
            end else begin
              ram_we     = 1'b1;
              wr_ptr_nxt = advance(wr_ptr_r);
              count_nxt  = count_r + 1'b1;
            end
          end
        end
        ACT_POP: begin
          if (!empty) begin
            res.pop_valid    = 1'b1;
            res.event_button = rd_data[EVENT_W-1];
            res.event_time   = rd_data[TIME_W-1:0];
            rd_ptr_nxt       = advance(rd_ptr_r);
            count_nxt        = count_r - 1'b1;
          end
        end
        ACT_FLUSH: begin
          rd_ptr_nxt = wr_ptr_r;
          count_nxt  = '0;
        end
        default: ;
      endcase
    end

    cnt_wide               = (PW + 3)'(count_nxt);
    res.first_press_total  = total_nxt[0];
    res.second_press_total = total_nxt[1];
    res.pending_count      = cnt_wide[PENDING_W-1:0];
  end

  assign ram_waddr   = wr_ptr_r;
  assign ram_wdata   = {item.button, item.now_ms};
  assign ram_raddr   = rd_ptr_nxt;
  assign byp_hit_nxt = ram_we && (wr_ptr_r == rd_ptr_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r   <= '0;
      rd_ptr_r   <= '0;
      count_r    <= '0;
      last_r[0]  <= '0;
      last_r[1]  <= '0;
      total_r[0] <= '0;
      total_r[1] <= '0;
      window_r   <= WINDOW_RESET;
      byp_hit_r  <= 1'b0;
    end else begin
      wr_ptr_r  <= wr_ptr_nxt;
      rd_ptr_r  <= rd_ptr_nxt;
      count_r   <= count_nxt;
      last_r    <= last_nxt;
      total_r   <= total_nxt;
      byp_hit_r <= byp_hit_nxt;
      if (cfg_we) begin
        window_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    byp_data_r <= ram_wdata;
  end

  `BDEQ_ASSERT_ALWAYS(a_count_max, clk, rst_n, count_r <= PW'(QUEUE_DEPTH - 1), "ring overfilled")
  `BDEQ_ASSERT_IMPLY(a_drop_full, clk, rst_n, res.event_dropped, res.press_accepted && full, "drop without full ring")
  `BDEQ_ASSERT_IMPLY(a_empty_ptrs, clk, rst_n, count_r == '0, wr_ptr_r == rd_ptr_r, "empty count but pointers differ")
  `BDEQ_ASSERT_NEXT(a_flush_clears, clk, rst_n, item_valid && item.action == ACT_FLUSH, count_r == '0, "flush left events")
  `BDEQ_ASSERT_NEXT(a_pop_moves, clk, rst_n, res.pop_valid, rd_ptr_r != $past(rd_ptr_r), "pop did not advance read pointer")

endmodule

// ===== rtl/button_debounce_event_queue.sv =====
// Channel   Dir  Beat contents
// in_if     in   action, button, now_ms
// out_if    out  press_accepted, event_dropped, pop_valid, event_button, event_time,
//                pending_count, first_press_total, second_press_total
// cfg_*     in   debounce_window_ms (write only)
//
// One beat per cycle sustained while the output takes results; each beat passes
// through the input register, then debounce and ring update into the result register.
// The ring RAM is read at the next read pointer with a one-entry write bypass.
// Reset is synchronous, active low; totals, last press times and pointers clear.
// A stalled output holds the result register; the input register fills behind it.

module button_debounce_event_queue #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  bdeq_in_if.sink      in_if,
  bdeq_out_if.source   out_if,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata
);
  import bdeq_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  logic         s1_valid_r, s1_valid_nxt;
  in_item_t     s1_item_r;
  logic         out_valid_r, out_valid_nxt;
  res_t         out_res_r;
  logic         in_fire;
  logic         fire;
  res_t         res;

  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [EVENT_W-1:0] ram_wdata;
  logic [PW-1:0]      ram_raddr;
  logic [EVENT_W-1:0] ram_rdata;

  assign fire          = s1_valid_r && (!out_valid_r || out_if.ready);
  // no beat is taken while reset is held
  assign in_if.ready   = rst_n && (!s1_valid_r || fire);
  assign in_fire       = in_if.valid && in_if.ready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !fire);
  assign out_valid_nxt = fire || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.action <= action_t'(in_if.action);
      s1_item_r.button <= in_if.button;
      s1_item_r.now_ms <= in_if.now_ms;
    end
    if (fire) begin
      out_res_r <= res;
    end
  end

  bdeq_core #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .item_valid (fire),
    .item       (s1_item_r),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata)
  );

  bdeq_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_if.valid              = out_valid_r;
  assign out_if.press_accepted     = out_res_r.press_accepted;
  assign out_if.event_dropped      = out_res_r.event_dropped;
  assign out_if.pop_valid          = out_res_r.pop_valid;
  assign out_if.event_button       = out_res_r.event_button;
  assign out_if.event_time         = out_res_r.event_time;
  assign out_if.pending_count      = out_res_r.pending_count;
  assign out_if.first_press_total  = out_res_r.first_press_total;
  assign out_if.second_press_total = out_res_r.second_press_total;

endmodule

// ===== dv/button_debounce_event_queue_test.sv =====
module button_debounce_event_queue_test;
  import bdeq_pkg::*;

  localparam int DEPTH       = 8;
  localparam int QUIET_LIMIT = 4000;
  localparam int SEG_BEATS   = 317;
  localparam logic [1:0] ACT_NOP = 2'd3;

  typedef enum logic {ROW_BEAT, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  act;
    logic        btn;
    logic [31:0] tm;
    bit          has_want;
    res_t        want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [15:0] cfg_wdata;

  bdeq_in_if  in_ch();
  bdeq_out_if out_ch();

  button_debounce_event_queue #(.QUEUE_DEPTH(DEPTH)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_ch),
    .out_if    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // shadow of the block: 8-slot ring, pointers wrap on their own width
  logic                     ring_btn [DEPTH];
  logic [31:0]              ring_ms  [DEPTH];
  logic [$clog2(DEPTH)-1:0] wr_ptr = '0;
  logic [$clog2(DEPTH)-1:0] rd_ptr = '0;
  logic [31:0]              last_ms   [2] = '{32'd0, 32'd0};
  logic [31:0]              press_cnt [2] = '{32'd0, 32'd0};
  logic [15:0]              window_ms = WINDOW_RESET;

  res_t     status_q [$];
  dir_row_t dir_rows [$];

  int snd_idle_pct;
  int rcv_stall_pct;
  int mismatches;
  int beats_in;
  int results_checked;
  int n_counted;
  int n_dropped;
  int n_popped;
  int n_flushed;
  int quiet_cycles;
  logic [31:0] clock_ms;

  task automatic debounce_step(input logic [1:0] act, input logic btn, input logic [31:0] tm,
                               output res_t r);
    logic [31:0] since;
    r = '0;
    since = tm - last_ms[btn];
    case (act)
      ACT_PRESS: begin
        if (since >= {16'd0, window_ms}) begin
          r.press_accepted = 1'b1;
          last_ms[btn] = tm;
          press_cnt[btn] = press_cnt[btn] + 32'd1;
          n_counted++;
          if (wr_ptr + 1'b1 == rd_ptr) begin
            // ring full: still counted, event lost
            r.event_dropped = 1'b1;
            n_dropped++;
          end else begin
            ring_btn[wr_ptr] = btn;
            ring_ms[wr_ptr] = tm;
            wr_ptr = wr_ptr + 1'b1;
          end
        end
      end
      ACT_POP: begin
        if (rd_ptr != wr_ptr) begin
          r.pop_valid = 1'b1;
          r.event_button = ring_btn[rd_ptr];
          r.event_time = ring_ms[rd_ptr];
          rd_ptr = rd_ptr + 1'b1;
          n_popped++;
        end
      end
      ACT_FLUSH: begin
        rd_ptr = wr_ptr;
        n_flushed++;
      end
      default: ;
    endcase
    r.pending_count = wr_ptr - rd_ptr;
    r.first_press_total = press_cnt[0];
    r.second_press_total = press_cnt[1];
  endtask

  task automatic add_row(input row_kind_t kind, input logic [1:0] act, input logic btn,
                         input logic [31:0] tm, input bit has_want, input res_t want);
    dir_row_t row;
    row.kind = kind;
    row.act = act;
    row.btn = btn;
    row.tm = tm;
    row.has_want = has_want;
    row.want = want;
    dir_rows.push_back(row);
  endtask

  // called at a rising edge; returns at the edge where the beat was taken
  task automatic send_beat(input logic [1:0] act, input logic btn, input logic [31:0] tm,
                           input bit has_want, input res_t want);
    res_t r;
    while ($urandom_range(99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.button <= btn;
    in_ch.now_ms <= tm;
    do @(posedge clk); while (!in_ch.ready);
    debounce_step(act, btn, tm, r);
    status_q.push_back(has_want ? want : r);
    beats_in++;
  endtask

  // stop sending, let the pipe empty, then change the window
  task automatic quiesce_and_set_window(input logic [15:0] w);
    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    window_ms = w;
  endtask

  function automatic void cmp_field(input string name, input logic [31:0] want,
                                    input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endfunction

  initial begin : result_check
    res_t got;
    res_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        got = '{out_ch.press_accepted, out_ch.event_dropped, out_ch.pop_valid,
                out_ch.event_button, out_ch.event_time, out_ch.pending_count,
                out_ch.first_press_total, out_ch.second_press_total};
        if (status_q.size() == 0) begin
          $error("result beat with nothing expected");
          mismatches++;
        end else begin
          want = status_q.pop_front();
          cmp_field("press_accepted", 32'(want.press_accepted), 32'(got.press_accepted));
          cmp_field("event_dropped", 32'(want.event_dropped), 32'(got.event_dropped));
          cmp_field("pop_valid", 32'(want.pop_valid), 32'(got.pop_valid));
          cmp_field("event_button", 32'(want.event_button), 32'(got.event_button));
          cmp_field("event_time", want.event_time, got.event_time);
          cmp_field("pending_count", 32'(want.pending_count), 32'(got.pending_count));
          cmp_field("first_press_total", want.first_press_total, got.first_press_total);
          cmp_field("second_press_total", want.second_press_total, got.second_press_total);
          results_checked++;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin : main
    logic [1:0]  act;
    logic        btn;
    logic [31:0] tm;
    logic [15:0] seg_window;
    bit          fill_mode;
    int          press_pct;
    int          pop_pct;
    int          roll;

    in_ch.valid  <= 1'b0;
    in_ch.action <= ACT_PRESS;
    in_ch.button <= 1'b0;
    in_ch.now_ms <= '0;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    snd_idle_pct  = 29;
    rcv_stall_pct = 75;
    quiet_cycles  = 0;
    clock_ms      = '0;
    fill_mode     = 1'b0;

    // directed rows, default window of 20 ms
    add_row(ROW_BEAT, ACT_POP,   1'b0, 32'd0, 1,
            res_t'{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 3'd0, 32'd0, 32'd0});
    add_row(ROW_BEAT, ACT_PRESS, 1'b0, 32'd5, 1,
            res_t'{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 3'd0, 32'd0, 32'd0});
    add_row(ROW_BEAT, ACT_PRESS, 1'b0, 32'd20, 1,
            res_t'{1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 3'd1, 32'd1, 32'd0});
    add_row(ROW_BEAT, ACT_PRESS, 1'b1, 32'hFFFF_FFFF, 1,
            res_t'{1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 3'd2, 32'd1, 32'd1});
    // time wrapped past zero: only 6 ms since the last press
    add_row(ROW_BEAT, ACT_PRESS, 1'b1, 32'd5, 1,
            res_t'{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 3'd2, 32'd1, 32'd1});
    // exactly one window after the last press, across the wrap
    add_row(ROW_BEAT, ACT_PRESS, 1'b1, 32'd19, 1,
            res_t'{1'b1, 1'b0, 1'b0, 1'b0, 32'd0, 3'd3, 32'd1, 32'd2});
    add_row(ROW_BEAT, ACT_POP,   1'b1, 32'hFFFF_FFFF, 1,
            res_t'{1'b0, 1'b0, 1'b1, 1'b0, 32'd20, 3'd2, 32'd1, 32'd2});
    add_row(ROW_BEAT, ACT_NOP,   1'b1, 32'hFFFF_FFFF, 1,
            res_t'{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 3'd2, 32'd1, 32'd2});
    add_row(ROW_BEAT, ACT_FLUSH, 1'b0, 32'd0, 1,
            res_t'{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 3'd0, 32'd1, 32'd2});
    add_row(ROW_BEAT, ACT_POP,   1'b0, 32'd0, 1,
            res_t'{1'b0, 1'b0, 1'b0, 1'b0, 32'd0, 3'd0, 32'd1, 32'd2});
    for (int k = 0; k < 7; k++) begin
      add_row(ROW_BEAT, ACT_PRESS, 1'b0, 32'd40 + 32'(k) * 32'd20, 0, '0);
    end
    // eighth press into a ring holding seven
    add_row(ROW_BEAT, ACT_PRESS, 1'b0, 32'd180, 1,
            res_t'{1'b1, 1'b1, 1'b0, 1'b0, 32'd0, 3'd7, 32'd9, 32'd2});
    add_row(ROW_BEAT, ACT_PRESS, 1'b1, 32'd181, 0, '0);
    add_row(ROW_BEAT, ACT_POP,   1'b0, 32'd0, 0, '0);
    add_row(ROW_BEAT, ACT_PRESS, 1'b1, 32'hFFFF_FFF0, 0, '0);
    add_row(ROW_CFG,  ACT_NOP,   1'b0, 32'd0, 0, '0);
    add_row(ROW_BEAT, ACT_PRESS, 1'b1, 32'hFFFF_FFF0, 0, '0);
    add_row(ROW_CFG,  ACT_NOP,   1'b0, 32'hFFFF, 0, '0);
    add_row(ROW_BEAT, ACT_PRESS, 1'b0, 32'd180 + 32'd65534, 0, '0);
    add_row(ROW_BEAT, ACT_PRESS, 1'b0, 32'd180 + 32'd65535, 0, '0);
    add_row(ROW_BEAT, ACT_FLUSH, 1'b0, 32'd0, 0, '0);
    add_row(ROW_BEAT, ACT_POP,   1'b1, 32'd0, 0, '0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[n]) begin
      if (dir_rows[n].kind == ROW_CFG) begin
        quiesce_and_set_window(dir_rows[n].tm[15:0]);
      end else begin
        send_beat(dir_rows[n].act, dir_rows[n].btn, dir_rows[n].tm,
                  dir_rows[n].has_want, dir_rows[n].want);
      end
    end

    // random segments: two per idle profile, each under its own window
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0:       seg_window = WINDOW_RESET;
        1:       seg_window = 16'd0;
        2:       seg_window = 16'hFFFF;
        3:       seg_window = 16'($urandom_range(1, 300));
        4:       seg_window = 16'($urandom_range(0, 65535));
        default: seg_window = 16'($urandom_range(2, 40));
      endcase
      case (seg / 2)
        0:       begin snd_idle_pct = 29; rcv_stall_pct = 75; end
        1:       begin snd_idle_pct = 75; rcv_stall_pct = 29; end
        default: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
      endcase
      quiesce_and_set_window(seg_window);
      for (int i = 0; i < SEG_BEATS; i++) begin
        // every 40 beats pick at random a burst that fills the ring or one that drains it
        if (i % 40 == 0) fill_mode = 1'($urandom_range(1));
        press_pct = fill_mode ? 70 : 35;
        pop_pct   = fill_mode ? 20 : 55;
        roll = $urandom_range(99);
        btn  = 1'($urandom_range(1));
        tm   = $urandom();
        if (roll < press_pct) begin
          act = ACT_PRESS;
          if ($urandom_range(99) < 3) begin
            clock_ms = $urandom();
          end else begin
            clock_ms = clock_ms + $urandom_range(0, {16'd0, window_ms} + 32'd4);
          end
          tm = clock_ms;
        end else if (roll < press_pct + pop_pct) begin
          act = ACT_POP;
        end else if (roll < 96) begin
          act = ACT_FLUSH;
        end else begin
          act = ACT_NOP;
        end
        send_beat(act, btn, tm, 0, '0);
      end
    end

    in_ch.valid <= 1'b0;
    while (status_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("run: %0d input beats, %0d results checked, six windows incl. 0 and 65535",
             beats_in, results_checked);
    $display("run: %0d presses counted, %0d dropped on full ring, %0d pops, %0d flushes",
             n_counted, n_dropped, n_popped, n_flushed);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bdeq_pkg.sv
rtl/bdeq_in_if.sv
rtl/bdeq_out_if.sv
rtl/bdeq_ram.sv
rtl/bdeq_core.sv
rtl/button_debounce_event_queue.sv
dv/button_debounce_event_queue_test.sv
